/* rtl/irpd_pkg.sv */
`timescale 1ns / 1ps
package irpd_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int BAND_W = 12;
	localparam int CODE_W = 25;
	localparam int KNOB_W = 8;

	localparam logic [2:0] REG_GAP_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_BAND_A_LOW  = 3'd1;
	localparam logic [2:0] REG_BAND_A_HIGH = 3'd2;
	localparam logic [2:0] REG_BAND_B_LOW  = 3'd3;
	localparam logic [2:0] REG_BAND_B_HIGH = 3'd4;
	localparam logic [2:0] REG_CODE_UP     = 3'd5;
	localparam logic [2:0] REG_CODE_DOWN   = 3'd6;
	localparam logic [2:0] REG_CODE_MUTE   = 3'd7;

	localparam logic [BAND_W-1:0] RST_GAP_TIMEOUT = 12'd500;
	localparam logic [BAND_W-1:0] RST_BAND_A_LOW  = 12'd750;
	localparam logic [BAND_W-1:0] RST_BAND_A_HIGH = 12'd850;
	localparam logic [BAND_W-1:0] RST_BAND_B_LOW  = 12'd350;
	localparam logic [BAND_W-1:0] RST_BAND_B_HIGH = 12'd450;
	localparam logic [CODE_W-1:0] RST_CODE_UP     = 25'd25;
	localparam logic [CODE_W-1:0] RST_CODE_DOWN   = 25'd98;
	localparam logic [CODE_W-1:0] RST_CODE_MUTE   = 25'd121;

	localparam logic [KNOB_W-1:0] VOLUME_MAX = 8'd178;
	localparam logic [KNOB_W-1:0] VOLUME_MIN = 8'd1;

	typedef struct packed {
		logic [BAND_W-1:0] gap_timeout;
		logic [BAND_W-1:0] band_a_low;
		logic [BAND_W-1:0] band_a_high;
		logic [BAND_W-1:0] band_b_low;
		logic [BAND_W-1:0] band_b_high;
		logic [CODE_W-1:0] code_up;
		logic [CODE_W-1:0] code_down;
		logic [CODE_W-1:0] code_mute;
	} cfg_t;

endpackage

/* rtl/irpd_cfg.sv */
`timescale 1ns / 1ps
module irpd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [irpd_pkg::ADDR_W-1:0]  paddr,
	input  logic [irpd_pkg::DATA_W-1:0]  pwdata,
	output logic [irpd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output irpd_pkg::cfg_t               cfg
);

	irpd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_timeout <= irpd_pkg::RST_GAP_TIMEOUT;
			cfg_q.band_a_low  <= irpd_pkg::RST_BAND_A_LOW;
			cfg_q.band_a_high <= irpd_pkg::RST_BAND_A_HIGH;
			cfg_q.band_b_low  <= irpd_pkg::RST_BAND_B_LOW;
			cfg_q.band_b_high <= irpd_pkg::RST_BAND_B_HIGH;
			cfg_q.code_up     <= irpd_pkg::RST_CODE_UP;
			cfg_q.code_down   <= irpd_pkg::RST_CODE_DOWN;
			cfg_q.code_mute   <= irpd_pkg::RST_CODE_MUTE;
		end else if (wr_en) begin
			unique case (idx)
				irpd_pkg::REG_GAP_TIMEOUT: cfg_q.gap_timeout <= pwdata[irpd_pkg::BAND_W-1:0];
				irpd_pkg::REG_BAND_A_LOW:  cfg_q.band_a_low  <= pwdata[irpd_pkg::BAND_W-1:0];
				irpd_pkg::REG_BAND_A_HIGH: cfg_q.band_a_high <= pwdata[irpd_pkg::BAND_W-1:0];
				irpd_pkg::REG_BAND_B_LOW:  cfg_q.band_b_low  <= pwdata[irpd_pkg::BAND_W-1:0];
				irpd_pkg::REG_BAND_B_HIGH: cfg_q.band_b_high <= pwdata[irpd_pkg::BAND_W-1:0];
				irpd_pkg::REG_CODE_UP:     cfg_q.code_up     <= pwdata[irpd_pkg::CODE_W-1:0];
				irpd_pkg::REG_CODE_DOWN:   cfg_q.code_down   <= pwdata[irpd_pkg::CODE_W-1:0];
				irpd_pkg::REG_CODE_MUTE:   cfg_q.code_mute   <= pwdata[irpd_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			irpd_pkg::REG_GAP_TIMEOUT: prdata = irpd_pkg::DATA_W'(cfg_q.gap_timeout);
			irpd_pkg::REG_BAND_A_LOW:  prdata = irpd_pkg::DATA_W'(cfg_q.band_a_low);
			irpd_pkg::REG_BAND_A_HIGH: prdata = irpd_pkg::DATA_W'(cfg_q.band_a_high);
			irpd_pkg::REG_BAND_B_LOW:  prdata = irpd_pkg::DATA_W'(cfg_q.band_b_low);
			irpd_pkg::REG_BAND_B_HIGH: prdata = irpd_pkg::DATA_W'(cfg_q.band_b_high);
			irpd_pkg::REG_CODE_UP:     prdata = irpd_pkg::DATA_W'(cfg_q.code_up);
			irpd_pkg::REG_CODE_DOWN:   prdata = irpd_pkg::DATA_W'(cfg_q.code_down);
			irpd_pkg::REG_CODE_MUTE:   prdata = irpd_pkg::DATA_W'(cfg_q.code_mute);
			default:                   prdata = '0;
		endcase
	end

endmodule

/* rtl/irpd_core.sv */
`timescale 1ns / 1ps
module irpd_core #(
	parameter int MAX_ENTRIES = 50,
	parameter int COUNT_WIDTH = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  irpd_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              ir_active,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [irpd_pkg::KNOB_W-1:0]       knob_position,
	output logic                              message_done,
	output logic [irpd_pkg::CODE_W-1:0]       message_code,
	output logic                              mute_state
);

	localparam int EC_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (COUNT_WIDTH > irpd_pkg::BAND_W) ? COUNT_WIDTH : irpd_pkg::BAND_W;
	localparam logic [EC_W-1:0] EC_LIMIT = EC_W'(MAX_ENTRIES);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_MARK  = 2'd1;
	localparam logic [1:0] PH_SPACE = 2'd2;

	logic [1:0]                    ph_q, ph_n;
	logic [COUNT_WIDTH-1:0]        dur_q, dur_n, dur_sat;
	logic [EC_W-1:0]               ec_q, ec_n, ec_w;
	logic [irpd_pkg::CODE_W-1:0]   cb_q, cb_n, cb_w, bit_mask;
	logic [irpd_pkg::KNOB_W-1:0]   vol_q, vol_n;
	logic                          mute_q, mute_n;
	logic                          done;
	logic [CMP_W-1:0]              len_x, dur_x;
	logic                          is_one;
	logic [EC_W-2:0]               pos;
	logic                          accept;

	logic [irpd_pkg::KNOB_W-1:0]   knob_q;
	logic                          done_q;
	logic [irpd_pkg::CODE_W-1:0]   code_q;
	logic                          mute_out_q;
	logic                          out_valid_q;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// band check on the finished entry length
	assign len_x  = CMP_W'(dur_q);
	assign is_one = (len_x > CMP_W'(cfg.band_a_low) && len_x < CMP_W'(cfg.band_a_high)) ||
	                (len_x > CMP_W'(cfg.band_b_low) && len_x < CMP_W'(cfg.band_b_high));

	assign ec_w    = (ec_q >= EC_LIMIT) ? '0 : ec_q;
	assign cb_w    = (ec_q >= EC_LIMIT) ? '0 : cb_q;
	assign pos     = ec_w[EC_W-1:1];
	assign dur_sat = (dur_q == '1) ? dur_q : dur_q + 1'b1;

	always_comb begin
		bit_mask = '0;
		for (int i = 0; i < irpd_pkg::CODE_W; i++) begin
			bit_mask[i] = (int'(pos) == i) & ~ec_w[0] & is_one;
		end
	end

	always_comb begin
		ph_n   = ph_q;
		dur_n  = dur_q;
		ec_n   = ec_w;
		cb_n   = cb_w;
		vol_n  = vol_q;
		mute_n = mute_q;
		done   = 1'b0;
		if (ir_active) begin
			unique case (ph_q)
				PH_MARK: dur_n = dur_sat;
				PH_SPACE: begin
					cb_n  = cb_w | bit_mask;
					ec_n  = ec_w + 1'b1;
					ph_n  = PH_MARK;
					dur_n = '0;
				end
				default: begin
					ph_n  = PH_MARK;
					dur_n = '0;
					ec_n  = '0;
					cb_n  = '0;
				end
			endcase
		end else begin
			unique case (ph_q)
				PH_MARK: begin
					cb_n  = cb_w | bit_mask;
					ec_n  = ec_w + 1'b1;
					ph_n  = PH_SPACE;
					dur_n = '0;
				end
				PH_SPACE: dur_n = dur_sat;
				default: ;
			endcase
		end
		dur_x = CMP_W'(dur_n);
		if (!ir_active && ph_n == PH_SPACE && dur_x > CMP_W'(cfg.gap_timeout)) begin
			done = 1'b1;
			ph_n = PH_IDLE;
			if (cb_n == cfg.code_up) begin
				vol_n = (vol_n < irpd_pkg::VOLUME_MAX) ? vol_n + 1'b1 : irpd_pkg::VOLUME_MAX;
			end
			if (cb_n == cfg.code_down) begin
				vol_n = (vol_n >= 8'd2) ? vol_n - 1'b1 : irpd_pkg::VOLUME_MIN;
			end
			if (cb_n == cfg.code_mute) begin
				mute_n = ~mute_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			dur_q  <= '0;
			ec_q   <= '0;
			cb_q   <= '0;
			vol_q  <= irpd_pkg::VOLUME_MIN;
			mute_q <= 1'b0;
		end else if (accept) begin
			ph_q   <= ph_n;
			dur_q  <= dur_n;
			ec_q   <= ec_n;
			cb_q   <= cb_n;
			vol_q  <= vol_n;
			mute_q <= mute_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			knob_q     <= mute_n ? irpd_pkg::VOLUME_MIN : vol_n;
			done_q     <= done;
			code_q     <= done ? cb_n : '0;
			mute_out_q <= mute_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign knob_position = knob_q;
	assign message_done  = done_q;
	assign message_code  = code_q;
	assign mute_state    = mute_out_q;

endmodule

/* rtl/ir_pulse_decoder_volume_knob.sv */
`timescale 1ns / 1ps
// An input transfer's result is registered in the output register; one sample
// per cycle while in_stall is low. The decoder state updates in a single pass.
// The output register accepts a new sample while the held result is taken.
// Reset (arst_n low, async): idle, counters and code cleared, volume 1, unmuted,
// configuration registers at their defaults.
module ir_pulse_decoder_volume_knob #(
	parameter int MAX_ENTRIES = 50,
	parameter int COUNT_WIDTH = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [irpd_pkg::ADDR_W-1:0]       paddr,
	input  logic [irpd_pkg::DATA_W-1:0]       pwdata,
	output logic [irpd_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              ir_active,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [irpd_pkg::KNOB_W-1:0]       knob_position,
	output logic                              message_done,
	output logic [irpd_pkg::CODE_W-1:0]       message_code,
	output logic                              mute_state
);

	irpd_pkg::cfg_t cfg;

	irpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	irpd_core #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.ir_active     (ir_active),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.knob_position (knob_position),
		.message_done  (message_done),
		.message_code  (message_code),
		.mute_state    (mute_state)
	);

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

	localparam int MAX_ENTRIES = 50;
	localparam int COUNT_WIDTH = 12;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_TRIAL_MARK = 15;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_MARK,
		RX_SPACE
	} rx_phase_t;

	typedef struct packed {
		logic [irpd_pkg::KNOB_W-1:0] knob;
		logic                        done;
		logic [irpd_pkg::CODE_W-1:0] code;
		logic                        mute;
	} knob_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [irpd_pkg::ADDR_W-1:0]   paddr;
	logic [irpd_pkg::DATA_W-1:0]   pwdata;
	logic [irpd_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic                          ir_active;
	logic                          out_valid;
	logic                          out_stall;
	logic [irpd_pkg::KNOB_W-1:0]   knob_position;
	logic                          message_done;
	logic [irpd_pkg::CODE_W-1:0]   message_code;
	logic                          mute_state;

	ir_pulse_decoder_volume_knob #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) dut (.*);

	// decoder state mirrored by the testbench
	irpd_pkg::cfg_t              decode_cfg;
	rx_phase_t                   rx_phase;
	logic [COUNT_WIDTH-1:0]      pulse_len;
	int                          entry_idx;
	logic [irpd_pkg::CODE_W-1:0] code_acc;
	logic [irpd_pkg::KNOB_W-1:0] volume;
	logic                        muted;

	knob_result_t pending_knob_results[$];
	int           mismatch_count = 0;
	int           samples_sent = 0;
	int           stuck_cycles = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial out_stall = 1'b0;
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic note_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("MISMATCH %s: expected 0x%0h got 0x%0h at %0t", what, exp_v, got_v,
				$realtime);
		end
	endtask

	function automatic void reset_model();
		decode_cfg = '{gap_timeout: irpd_pkg::RST_GAP_TIMEOUT,
			band_a_low: irpd_pkg::RST_BAND_A_LOW,
			band_a_high: irpd_pkg::RST_BAND_A_HIGH,
			band_b_low: irpd_pkg::RST_BAND_B_LOW,
			band_b_high: irpd_pkg::RST_BAND_B_HIGH,
			code_up: irpd_pkg::RST_CODE_UP,
			code_down: irpd_pkg::RST_CODE_DOWN,
			code_mute: irpd_pkg::RST_CODE_MUTE};
		rx_phase = RX_IDLE;
		pulse_len = '0;
		entry_idx = 0;
		code_acc = '0;
		volume = irpd_pkg::VOLUME_MIN;
		muted = 1'b0;
	endfunction

	function automatic logic in_band(input logic [COUNT_WIDTH-1:0] len);
		return (len > decode_cfg.band_a_low && len < decode_cfg.band_a_high) ||
			(len > decode_cfg.band_b_low && len < decode_cfg.band_b_high);
	endfunction

	function automatic void log_entry(input logic [COUNT_WIDTH-1:0] len);
		if (entry_idx[0] == 1'b0 && in_band(len) && (entry_idx >> 1) < irpd_pkg::CODE_W) begin
			code_acc[entry_idx >> 1] = 1'b1;
		end
		entry_idx++;
	endfunction

	function automatic void predict_knob_tick(input logic active);
		knob_result_t r;
		r.done = 1'b0;
		r.code = '0;
		if (entry_idx >= MAX_ENTRIES) begin
			entry_idx = 0;
			code_acc = '0;
		end
		if (active) begin
			case (rx_phase)
				RX_MARK: begin
					if (pulse_len < COUNT_MAX) pulse_len++;
				end
				RX_SPACE: begin
					log_entry(pulse_len);
					rx_phase = RX_MARK;
					pulse_len = '0;
				end
				default: begin
					rx_phase = RX_MARK;
					pulse_len = '0;
					entry_idx = 0;
					code_acc = '0;
				end
			endcase
		end else begin
			if (rx_phase == RX_MARK) begin
				log_entry(pulse_len);
				rx_phase = RX_SPACE;
				pulse_len = '0;
			end else if (rx_phase == RX_SPACE && pulse_len < COUNT_MAX) begin
				pulse_len++;
			end
			if (rx_phase == RX_SPACE && pulse_len > decode_cfg.gap_timeout) begin
				r.done = 1'b1;
				r.code = code_acc;
				if (r.code == decode_cfg.code_up) begin
					volume = (volume < irpd_pkg::VOLUME_MAX) ? volume + 1'b1 :
						irpd_pkg::VOLUME_MAX;
				end
				if (r.code == decode_cfg.code_down) begin
					volume = (volume > irpd_pkg::VOLUME_MIN) ? volume - 1'b1 :
						irpd_pkg::VOLUME_MIN;
				end
				if (r.code == decode_cfg.code_mute) muted = ~muted;
				rx_phase = RX_IDLE;
			end
		end
		r.knob = muted ? irpd_pkg::VOLUME_MIN : volume;
		r.mute = muted;
		pending_knob_results.push_back(r);
	endfunction

	function automatic void set_reg(input logic [2:0] idx, input logic [31:0] value);
		case (idx)
			irpd_pkg::REG_GAP_TIMEOUT: decode_cfg.gap_timeout = value[irpd_pkg::BAND_W-1:0];
			irpd_pkg::REG_BAND_A_LOW:  decode_cfg.band_a_low = value[irpd_pkg::BAND_W-1:0];
			irpd_pkg::REG_BAND_A_HIGH: decode_cfg.band_a_high = value[irpd_pkg::BAND_W-1:0];
			irpd_pkg::REG_BAND_B_LOW:  decode_cfg.band_b_low = value[irpd_pkg::BAND_W-1:0];
			irpd_pkg::REG_BAND_B_HIGH: decode_cfg.band_b_high = value[irpd_pkg::BAND_W-1:0];
			irpd_pkg::REG_CODE_UP:     decode_cfg.code_up = value[irpd_pkg::CODE_W-1:0];
			irpd_pkg::REG_CODE_DOWN:   decode_cfg.code_down = value[irpd_pkg::CODE_W-1:0];
			default:                   decode_cfg.code_mute = value[irpd_pkg::CODE_W-1:0];
		endcase
	endfunction

	function automatic logic [31:0] reg_value(input irpd_pkg::cfg_t c, input logic [2:0] idx);
		case (idx)
			irpd_pkg::REG_GAP_TIMEOUT: return 32'(c.gap_timeout);
			irpd_pkg::REG_BAND_A_LOW:  return 32'(c.band_a_low);
			irpd_pkg::REG_BAND_A_HIGH: return 32'(c.band_a_high);
			irpd_pkg::REG_BAND_B_LOW:  return 32'(c.band_b_low);
			irpd_pkg::REG_BAND_B_HIGH: return 32'(c.band_b_high);
			irpd_pkg::REG_CODE_UP:     return 32'(c.code_up);
			irpd_pkg::REG_CODE_DOWN:   return 32'(c.code_down);
			default:                   return 32'(c.code_mute);
		endcase
	endfunction

	// all driver tasks start and end at a falling edge
	task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		if (wr) set_reg(idx, wdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_registers();
		logic [31:0] rd;
		for (int i = 0; i <= irpd_pkg::REG_CODE_MUTE; i++) begin
			apb_access(1'b0, 3'(i), '0, rd);
			if (rd !== reg_value(decode_cfg, 3'(i))) begin
				note_mismatch($sformatf("register %0d readback", i),
					reg_value(decode_cfg, 3'(i)), rd);
			end
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_knob_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_config(input irpd_pkg::cfg_t c);
		logic [31:0] rd;
		logic [31:0] junk;
		int          w;
		drain_results();
		for (int i = 0; i <= irpd_pkg::REG_CODE_MUTE; i++) begin
			w = (3'(i) >= irpd_pkg::REG_CODE_UP) ? irpd_pkg::CODE_W : irpd_pkg::BAND_W;
			junk = $urandom_range(1) ? (($urandom() >> w) << w) : '0;
			apb_access(1'b1, 3'(i), reg_value(c, 3'(i)) | junk, rd);
		end
		check_registers();
	endtask

	task automatic send_sample(input logic active);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			ir_active <= 1'($urandom_range(1));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ir_active <= active;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_knob_tick(active);
		samples_sent++;
		@(negedge clk);
	endtask

	function automatic int pick_mark_len(input logic one);
		int d;
		for (int t = 0; t < 20; t++) begin
			d = $urandom_range(MAX_TRIAL_MARK);
			if (in_band(COUNT_WIDTH'(d)) == one) return d;
		end
		for (d = 0; d <= MAX_TRIAL_MARK; d++) begin
			if (in_band(COUNT_WIDTH'(d)) == one) return d;
		end
		return $urandom_range(MAX_TRIAL_MARK);
	endfunction

	task automatic send_message(input logic [irpd_pkg::CODE_W-1:0] code, input int nbits,
			input logic finish_it);
		int mark_len;
		int gap_len;
		for (int b = 0; b < nbits; b++) begin
			mark_len = pick_mark_len((b < irpd_pkg::CODE_W) ? code[b] : 1'b0);
			repeat (mark_len + 1) send_sample(1'b1);
			if (b < nbits - 1 || !finish_it) begin
				gap_len = $urandom_range(1, (decode_cfg.gap_timeout < 3) ?
					decode_cfg.gap_timeout + 1 : 4);
				repeat (gap_len) send_sample(1'b0);
			end
		end
		if (finish_it) repeat (decode_cfg.gap_timeout + 2 + $urandom_range(2)) send_sample(1'b0);
	endtask

	function automatic int code_span(input logic [irpd_pkg::CODE_W-1:0] code);
		for (int b = irpd_pkg::CODE_W - 1; b > 0; b--) begin
			if (code[b]) return b + 1;
		end
		return 1;
	endfunction

	function automatic irpd_pkg::cfg_t random_config();
		irpd_pkg::cfg_t c;
		c.gap_timeout = 12'($urandom_range(1, 6));
		c.band_a_low = 12'($urandom_range(0, 3));
		c.band_a_high = c.band_a_low + 12'($urandom_range(2, 4));
		c.band_b_low = c.band_a_high + 12'($urandom_range(0, 2));
		c.band_b_high = c.band_b_low + 12'($urandom_range(2, 4));
		if ($urandom_range(5) == 0) begin
			c.band_a_low = '0;
			c.band_a_high = '1;
		end
		if ($urandom_range(5) == 0) begin
			c.band_b_low = '1;
			c.band_b_high = '0;
		end
		c.code_up = 25'($urandom_range(15));
		c.code_down = 25'($urandom_range(15));
		c.code_mute = 25'($urandom_range(15));
		if ($urandom_range(7) == 0) c.code_down = c.code_up;
		return c;
	endfunction

	function automatic irpd_pkg::cfg_t empty_band_config();
		irpd_pkg::cfg_t c;
		c = decode_cfg;
		c.gap_timeout = 12'd1;
		c.band_a_low = '1;
		c.band_a_high = '0;
		c.band_b_low = '1;
		c.band_b_high = '0;
		c.code_up = '1;
		c.code_down = '1;
		c.code_mute = '1;
		return c;
	endfunction

	task automatic test_register_defaults();
		check_registers();
		repeat (3) send_sample(1'b0);
		repeat (4) send_sample(1'b1);
		repeat (3) send_sample(1'b0);
	endtask

	task automatic test_band_edges();
		irpd_pkg::cfg_t c;
		int             lens[8] = '{2, 3, 4, 5, 6, 7, 8, 9};
		c = decode_cfg;
		c.gap_timeout = 12'd3;
		c.band_a_low = 12'd2;
		c.band_a_high = 12'd5;
		c.band_b_low = 12'd7;
		c.band_b_high = 12'd9;
		c.code_up = 25'b1000110;
		load_config(c);
		foreach (lens[i]) begin
			repeat (lens[i] + 1) send_sample(1'b1);
			repeat (2) send_sample(1'b0);
		end
		repeat (3) send_sample(1'b0);
		c.band_a_low = '0;
		c.band_a_high = '1;
		c.band_b_low = '1;
		c.band_b_high = '0;
		c.code_down = 25'b10;
		load_config(c);
		send_sample(1'b1);
		send_sample(1'b0);
		repeat (2) send_sample(1'b1);
		repeat (5) send_sample(1'b0);
	endtask

	task automatic test_command_codes();
		irpd_pkg::cfg_t c;
		c = empty_band_config();
		c.code_up = '0;
		load_config(c);
		send_message('0, 1, 1'b1);
		c.code_up = '1;
		c.code_down = '0;
		load_config(c);
		send_message('0, 1, 1'b1);
		c.code_down = '1;
		c.code_mute = '0;
		load_config(c);
		repeat (2) send_message('0, 1, 1'b1);
		// all three commands on one code
		c.code_up = '0;
		c.code_down = '0;
		load_config(c);
		repeat (3) send_message('0, 1, 1'b1);
	endtask

	task automatic test_volume_limits();
		irpd_pkg::cfg_t c;
		c = empty_band_config();
		c.code_down = '0;
		load_config(c);
		repeat (2) send_message('0, 1, 1'b1);
		c.code_down = '1;
		c.code_up = '0;
		load_config(c);
		repeat (irpd_pkg::VOLUME_MAX + 2) send_message('0, 1, 1'b1);
		c.code_up = '1;
		c.code_down = '0;
		load_config(c);
		repeat (irpd_pkg::VOLUME_MAX + 2) send_message('0, 1, 1'b1);
	endtask

	task automatic test_full_code_and_wrap();
		irpd_pkg::cfg_t c;
		c = empty_band_config();
		c.gap_timeout = 12'd2;
		c.band_a_low = '0;
		c.band_a_high = '1;
		c.code_mute = '1;
		c.code_up = '0;
		c.code_down = 25'($urandom());
		load_config(c);
		send_message('1, irpd_pkg::CODE_W, 1'b1);
		send_message('0, 1, 1'b1);
		send_message(25'($urandom()), irpd_pkg::CODE_W + 5, 1'b1);
	endtask

	task automatic test_counter_saturation();
		irpd_pkg::cfg_t c;
		c = decode_cfg;
		c.gap_timeout = '1;
		load_config(c);
		repeat (int'(COUNT_MAX) + 5) send_sample(1'b1);
		repeat (int'(COUNT_MAX) + 5) send_sample(1'b0);
		c.gap_timeout = COUNT_MAX - 1'b1;
		load_config(c);
		repeat (2) send_sample(1'b0);
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int budget);
		int                          stop_at;
		int                          pick;
		bit                          paused;
		logic [irpd_pkg::CODE_W-1:0] code;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		load_config(random_config());
		stop_at = samples_sent + budget;
		paused = 0;
		while (samples_sent < stop_at) begin
			if (!paused && samples_sent >= stop_at - budget / 2) begin
				paused = 1;
				load_config(random_config());
			end
			pick = $urandom_range(19);
			if (pick < 13) begin
				case ($urandom_range(2))
					0: code = decode_cfg.code_up;
					1: code = decode_cfg.code_down;
					default: code = decode_cfg.code_mute;
				endcase
				send_message(code, code_span(code) + $urandom_range(1), 1'b1);
			end else if (pick < 15) begin
				send_message(25'($urandom_range(31)), $urandom_range(1, 5), 1'b1);
			end else if (pick < 17) begin
				send_message(25'($urandom_range(15)), $urandom_range(1, 4), 1'b0);
				repeat ($urandom_range(1, 6)) send_sample(1'($urandom_range(1)));
			end else if (pick < 19) begin
				repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(1)));
			end else begin
				send_message(25'($urandom()), $urandom_range(20, 28), 1'b1);
			end
		end
	endtask

	always @(posedge clk) begin
		knob_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_knob_results.size() == 0) begin
				note_mismatch("transfer with nothing pending", '0, 32'(knob_position));
			end else begin
				want = pending_knob_results.pop_front();
				if (knob_position !== want.knob) begin
					note_mismatch("knob_position", 32'(want.knob), 32'(knob_position));
				end
				if (message_done !== want.done) begin
					note_mismatch("message_done", 32'(want.done), 32'(message_done));
				end
				if (message_code !== want.code) begin
					note_mismatch("message_code", 32'(want.code), 32'(message_code));
				end
				if (mute_state !== want.mute) begin
					note_mismatch("mute_state", 32'(want.mute), 32'(mute_state));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		ir_active = 1'b0;
		reset_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_register_defaults();
		test_band_edges();
		test_command_codes();
		test_volume_limits();
		test_full_code_and_wrap();
		test_counter_saturation();
		run_random_phase(0, 0, 190);
		run_random_phase(84, 0, 190);
		run_random_phase(0, 84, 190);
		run_random_phase(38, 38, 190);
		drain_results();
		if (mismatch_count == 0 && pending_knob_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
